// File: hdl/swm_pkg.sv
package swm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 16;
	localparam int CFG_W    = 11;

	// one accepted word, tagged by the front end
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       first;
		logic        [POS_W-1:0]    pos;
		logic                       emit;
		logic        [POS_W-1:0]    start;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] window_max;
		logic        [POS_W-1:0]    window_start;
	} result_t;

endpackage

// File: hdl/sliding_window_maximum.sv
// Sliding window maximum over a stream of signed 32-bit samples.
// Input side is a queue: a word (sample, first) is taken on a rising edge with
// push high and full low. first restarts the sequence and empties the window.
// Result side is a queue: while empty is low the oldest result sits on
// window_max / window_start, and pop takes it. A result comes out for every
// sample once window_size samples of the current sequence have arrived.
// window_size is written through window_size_wr / window_size while idle; the
// block does not enforce that, the user must keep to it. Zero acts as one,
// values above WINDOW_MAX act as WINDOW_MAX. The front end tags each word
// (position, result or not) into a two-word queue; the back end runs the
// deque in a single memory with two registered read ports. The back end loads
// a word, then expires or pops one deque entry per step, then appends it and
// hands on its result; it takes no new word until done with the last one.
// When pop is held low the two-word result queue fills, the back end holds,
// then the input queue fills and full rises. Reset empties both queues and
// the deque and sets window_size to 1; no memory clearing is needed.
module sliding_window_maximum
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       window_size_wr,
	input  logic        [CFG_W-1:0]    window_size,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       first,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [SAMPLE_W-1:0] window_max,
	output logic        [POS_W-1:0]    window_start
);

	localparam int KMAX = (WINDOW_MAX > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : WINDOW_MAX;

	logic [CFG_W-1:0] window_size_q;
	logic [CFG_W-1:0] k;
	logic             fq_push;
	item_t            fq_wdata;
	logic             fq_full;
	logic             fq_valid;
	logic             fq_pop;
	item_t            fq_rdata;
	logic             rq_push;
	result_t          rq_wdata;
	logic             rq_full;
	logic             rq_valid;
	result_t          rq_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_size_q <= CFG_W'(1);
		else if (window_size_wr)
			window_size_q <= window_size;
	end

	always_comb begin
		priority if (window_size_q == '0)
			k = CFG_W'(1);
		else if (window_size_q > CFG_W'(KMAX))
			k = CFG_W'(KMAX);
		else
			k = window_size_q;
	end

	swm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sample (sample),
		.first  (first),
		.k      (k),
		.q_full (fq_full),
		.q_push (fq_push),
		.q_item (fq_wdata)
	);

	swm_fifo #(.W($bits(item_t))) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_push),
		.wdata  (fq_wdata),
		.full   (fq_full),
		.rd     (fq_pop),
		.rdata  (fq_rdata),
		.valid  (fq_valid)
	);

	swm_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.k        (k),
		.q_valid  (fq_valid),
		.q_item   (fq_rdata),
		.q_pop    (fq_pop),
		.res_full (rq_full),
		.res_push (rq_push),
		.res      (rq_wdata)
	);

	swm_fifo #(.W($bits(result_t))) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.rd     (pop),
		.rdata  (rq_rdata),
		.valid  (rq_valid)
	);

	assign full         = fq_full;
	assign empty        = ~rq_valid;
	assign window_max   = rq_rdata.window_max;
	assign window_start = rq_rdata.window_start;

endmodule

// File: hdl/swm_fifo.sv
module swm_fifo
	import swm_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         valid
);

	logic [W-1:0] data_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = data_q[rd_ptr_q];
	assign do_wr = wr & ~full;
	assign do_rd = rd & valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			data_q[wr_ptr_q] <= wdata;
	end

endmodule

// File: hdl/swm_front.sv
module swm_front
	import swm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       first,
	input  logic        [CFG_W-1:0]    k,
	input  logic                       q_full,
	output logic                       q_push,
	output item_t                      q_item
);

	logic [POS_W-1:0] seq_pos_q;
	logic [CFG_W-1:0] seen_q;
	logic [POS_W-1:0] pos;
	logic [CFG_W-1:0] seen_cur;
	logic [CFG_W-1:0] seen_nxt;

	assign q_push = push & ~q_full;

	always_comb begin
		pos      = first ? '0 : seq_pos_q;
		seen_cur = first ? '0 : seen_q;
		// count up, saturate at the window size
		seen_nxt = (seen_cur < k) ? seen_cur + CFG_W'(1) : seen_cur;
		q_item.sample = sample;
		q_item.first  = first;
		q_item.pos    = pos;
		q_item.emit   = (seen_nxt >= k);
		q_item.start  = pos - POS_W'(k) + POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_pos_q <= '0;
			seen_q    <= '0;
		end else if (q_push) begin
			seq_pos_q <= pos + POS_W'(1);
			seen_q    <= seen_nxt;
		end
	end

endmodule

// File: hdl/swm_back.sv
module swm_back
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] k,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	input  logic             res_full,
	output logic             res_push,
	output result_t          res
);

	localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CW    = $clog2(WINDOW_MAX + 1);
	localparam int MEM_W = SAMPLE_W + POS_W;

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic [MEM_W-1:0] dq_mem [WINDOW_MAX];
	logic [MEM_W-1:0] rd_head_q;
	logic [MEM_W-1:0] rd_tail_q;

	logic          st_q, st_n;
	logic [AW-1:0] head_q, head_n;
	logic [CW-1:0] count_q, count_n;
	item_t         item_q;
	logic          item_ld;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] raddr_head;
	logic [AW-1:0] raddr_tail;
	logic [POS_W-1:0] age;
	logic          drop_head;
	logic          pop_tail;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(h) + (CW+1)'(off);
		if (sum >= (CW+1)'(WINDOW_MAX))
			sum = sum - (CW+1)'(WINDOW_MAX);
		return sum[AW-1:0];
	endfunction

	assign age       = item_q.pos - rd_head_q[POS_W-1:0];
	assign drop_head = (count_q != '0) && (age >= POS_W'(k));
	assign pop_tail  = (count_q != '0) &&
		($signed(rd_tail_q[MEM_W-1:POS_W]) <= item_q.sample);
	assign wr_addr   = slot(head_q, count_q);

	assign res.window_max   = (count_q == '0) ? item_q.sample
		: $signed(rd_head_q[MEM_W-1:POS_W]);
	assign res.window_start = item_q.start;

	always_comb begin
		st_n     = st_q;
		head_n   = head_q;
		count_n  = count_q;
		item_ld  = 1'b0;
		q_pop    = 1'b0;
		wr_en    = 1'b0;
		res_push = 1'b0;
		unique case (st_q)
			ST_LOAD: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					item_ld = 1'b1;
					st_n    = ST_EVAL;
					if (q_item.first) begin
						head_n  = '0;
						count_n = '0;
					end
				end
			end
			ST_EVAL: begin
				priority if (drop_head) begin
					head_n  = slot(head_q, CW'(1));
					count_n = count_q - CW'(1);
				end else if (pop_tail) begin
					count_n = count_q - CW'(1);
				end else if (!item_q.emit || !res_full) begin
					// append; hand over head (or sample if empty) as max
					wr_en    = 1'b1;
					count_n  = count_q + CW'(1);
					res_push = item_q.emit;
					st_n     = ST_LOAD;
				end
			end
			default: st_n = ST_LOAD;
		endcase
		raddr_head = head_n;
		raddr_tail = slot(head_n, (count_n == '0) ? '0 : count_n - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			st_q    <= st_n;
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ld)
			item_q <= q_item;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			dq_mem[wr_addr] <= {item_q.sample, item_q.pos};
		rd_head_q <= dq_mem[raddr_head];
		rd_tail_q <= dq_mem[raddr_tail];
	end

endmodule

// File: verif/tb_sliding_window_maximum.sv
module tb_sliding_window_maximum;
	import swm_pkg::*;

	localparam int WIN_MAX = 1024;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_FLAT,
		SHAPE_RISE,
		SHAPE_FALL,
		SHAPE_EXTREME
	} shape_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       window_size_wr = 1'b0;
	logic        [CFG_W-1:0]    window_size = '0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       first = 1'b0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic signed [SAMPLE_W-1:0] window_max;
	logic        [POS_W-1:0]    window_start;

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;

	// shadow of the block's deque and counters
	logic signed [SAMPLE_W-1:0] dq_val [WIN_MAX];
	logic        [POS_W-1:0]    dq_pos [WIN_MAX];
	logic        [9:0]          dq_head = '0;
	int unsigned                dq_count = 0;
	logic        [POS_W-1:0]    next_pos = '0;
	int unsigned                filled = 0;
	logic        [CFG_W-1:0]    win_reg = 11'd1;

	result_t pending_maxima[$];

	sliding_window_maximum dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_size_wr(window_size_wr),
		.window_size   (window_size),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.first         (first),
		.empty         (empty),
		.pop           (pop),
		.window_max    (window_max),
		.window_start  (window_start)
	);

	always #5 clk = ~clk;

	function automatic int eff_window();
		if (win_reg == 0)
			return 1;
		if (win_reg > WIN_MAX)
			return WIN_MAX;
		return int'(win_reg);
	endfunction

	function automatic int settle_cycles();
		return 4 * (eff_window() + 4) + 20;
	endfunction

	task automatic advance_window(input logic signed [SAMPLE_W-1:0] s, input logic f);
		int unsigned k;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] age;
		logic [9:0] t;
		result_t r;
		k = eff_window();
		if (f) begin
			dq_head = '0;
			dq_count = 0;
			next_pos = '0;
			filled = 0;
		end
		p = next_pos;
		// drop entries that have aged out of the window
		while (dq_count > 0) begin
			age = p - dq_pos[dq_head];
			if (age < k)
				break;
			dq_head = dq_head + 10'd1;
			dq_count--;
		end
		while (dq_count > 0 && dq_val[10'(dq_head + dq_count - 1)] <= s)
			dq_count--;
		t = 10'(dq_head + dq_count);
		dq_val[t] = s;
		dq_pos[t] = p;
		dq_count++;
		next_pos = p + 16'd1;
		if (filled < k)
			filled++;
		if (filled >= k) begin
			r.window_max = dq_val[dq_head];
			r.window_start = 16'(p - (k - 1));
			pending_maxima.push_back(r);
		end
	endtask

	task automatic set_idling(input int gap, input int stall);
		gap_pct = gap;
		stall_pct = stall;
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic f);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= s;
		first <= f;
		@(posedge clk);
		while (full)
			@(posedge clk);
		advance_window(s, f);
		@(negedge clk);
	endtask

	// hold input until every maximum is out and the back end has gone quiet
	task automatic wait_drained();
		push <= 1'b0;
		while (pending_maxima.size() != 0)
			@(negedge clk);
		repeat (settle_cycles())
			@(negedge clk);
	endtask

	task automatic load_window_size(input logic [CFG_W-1:0] v);
		wait_drained();
		window_size_wr <= 1'b1;
		window_size <= v;
		@(negedge clk);
		window_size_wr <= 1'b0;
		win_reg = v;
	endtask

	function automatic logic [CFG_W-1:0] pick_window();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 14)
			return CFG_W'($urandom_range(1025, 2047));
		if (r < 30)
			return CFG_W'($urandom_range(16, 64));
		return CFG_W'($urandom_range(1, 9));
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] next_sample(input shape_t shape,
			input logic signed [SAMPLE_W-1:0] prev);
		case (shape)
			SHAPE_FLAT: begin
				return $urandom_range(8) - 4;
			end
			SHAPE_RISE: begin
				return prev + $urandom_range(3);
			end
			SHAPE_FALL: begin
				return prev - $urandom_range(3);
			end
			SHAPE_EXTREME: begin
				case ($urandom_range(3))
					0: return S_MIN;
					1: return S_MAX;
					2: return '0;
					default: return -1;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic test_single_sample_extremes();
		// reset leaves a one-sample window
		push_sample(S_MAX, 1'b1);
		push_sample(S_MIN, 1'b0);
		push_sample('0, 1'b0);
		push_sample(-1, 1'b0);
	endtask

	task automatic test_deque_order();
		load_window_size(11'd3);
		push_sample(5, 1'b1);
		push_sample(5, 1'b0);
		push_sample(3, 1'b0);
		push_sample(S_MIN, 1'b0);
		push_sample(S_MAX, 1'b0);
		push_sample(-1, 1'b0);
		push_sample(-2, 1'b0);
		push_sample(-3, 1'b0);
		// restart while the deque is still populated
		push_sample(7, 1'b1);
		push_sample(-7, 1'b0);
		push_sample(1, 1'b0);
	endtask

	task automatic test_size_limits();
		load_window_size('0);
		push_sample(42, 1'b1);
		push_sample(-42, 1'b0);
		load_window_size(11'h7ff);
		push_sample(1, 1'b1);
		push_sample(2, 1'b0);
	endtask

	task automatic test_resize_mid_sequence();
		load_window_size(11'd4);
		push_sample(9, 1'b1);
		push_sample(1, 1'b0);
		push_sample(8, 1'b0);
		push_sample(2, 1'b0);
		push_sample(3, 1'b0);
		load_window_size(11'd2);
		push_sample(4, 1'b0);
		push_sample(6, 1'b0);
		load_window_size(11'd6);
		push_sample('0, 1'b0);
		push_sample(5, 1'b0);
	endtask

	task automatic test_random_sequences(input int n_words);
		int sent;
		int len;
		int cap;
		shape_t shape;
		logic signed [SAMPLE_W-1:0] s;
		logic f;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(3) == 0)
				load_window_size(pick_window());
			else if ($urandom_range(5) == 0)
				wait_drained();
			cap = 3 * eff_window() + 6;
			if (cap > 60)
				cap = 60;
			len = $urandom_range(1, cap);
			shape = shape_t'($urandom_range(4));
			s = $urandom;
			for (int i = 0; i < len; i++) begin
				s = next_sample(shape, s);
				// mostly clean sequences, some continuations and stray restarts
				f = (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(49) == 0);
				push_sample(s, f);
			end
			sent += len;
		end
	endtask

	always @(negedge clk)
		pop <= arst_n && ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_maxima.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: max %0d start %0d", window_max, window_start);
			end else begin
				want = pending_maxima.pop_front();
				if (window_max !== want.window_max || window_start !== want.window_start) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected max %0d start %0d, got max %0d start %0d",
							want.window_max, want.window_start, window_max, window_start);
				end
			end
		end
	end

	initial begin
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(0, 0);
		test_single_sample_extremes();
		test_deque_order();
		test_size_limits();
		test_resize_mid_sequence();

		set_idling(0, 0);
		test_random_sequences(262);
		set_idling(60, 0);
		test_random_sequences(262);
		set_idling(0, 60);
		test_random_sequences(262);
		set_idling(33, 33);
		test_random_sequences(262);

		wait_drained();
		if (mismatches == 0 && pending_maxima.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#30000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hdl/swm_pkg.sv
hdl/swm_fifo.sv
hdl/swm_front.sv
hdl/swm_back.sv
hdl/sliding_window_maximum.sv
verif/tb_sliding_window_maximum.sv
